// File: rtl/hrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_pkg - shared types, codes and byte helpers of the response deframer
// Phase codes, result codes, match strings and the per-byte line parser.
// ----------------------------------------------------------------------------
package hrd_pkg;

  // parser phases
  localparam logic [3:0] PH_STATUS  = 4'd0;
  localparam logic [3:0] PH_HNAME   = 4'd1;
  localparam logic [3:0] PH_HVALUE  = 4'd2;
  localparam logic [3:0] PH_CHLINE  = 4'd3;
  localparam logic [3:0] PH_CHDATA  = 4'd4;
  localparam logic [3:0] PH_CHCR    = 4'd5;
  localparam logic [3:0] PH_CHLF    = 4'd6;
  localparam logic [3:0] PH_TRAILER = 4'd7;
  localparam logic [3:0] PH_LENGTH  = 4'd8;
  localparam logic [3:0] PH_CLOSE   = 4'd9;
  localparam logic [3:0] PH_DONE    = 4'd10;

  // result kinds and error codes
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_PROTO  = 2'd0;
  localparam logic [1:0] ERR_BIG    = 2'd1;
  localparam logic [1:0] ERR_CLOSED = 2'd2;

  // value token kinds
  localparam logic [1:0] TOK_OTHER = 2'd0;
  localparam logic [1:0] TOK_DEC   = 2'd1;
  localparam logic [1:0] TOK_TE    = 2'd2;
  localparam logic [1:0] TOK_HEX   = 2'd3;

  // register indexes
  localparam logic REG_HEAD_LIMIT = 1'b0;
  localparam logic REG_BODY_LIMIT = 1'b1;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_COL  = 8'h3A;

  localparam logic [4:0] DEC_DIGITS_MAX = 5'd19;
  localparam logic [4:0] HEX_DIGITS_MAX = 5'd15;
  localparam logic [9:0] STATUS_TOP     = 10'd599;

  // match strings, first char in the top byte, zero padded at the bottom
  localparam logic [7:0][7:0]  PROTO_TAG = {"HTTP/1.", 8'h00};
  localparam logic [15:0][7:0] CL_NAME   = {"content-length", 16'h0000};
  localparam logic [31:0][7:0] TE_NAME   = {"transfer-encoding", 120'h0};
  localparam logic [7:0][7:0]  TE_VALUE  = {"chunked", 8'h00};

  typedef struct packed {
    logic [3:0]  phase;
    logic [8:0]  line_pos;
    logic [9:0]  status_value;
    logic        head_error;
    logic [1:0]  name_match;
    logic [63:0] value_accum;
    logic [4:0]  digit_count;
    logic        val_started;
    logic        val_gap;
    logic        val_bad;
    logic        semi_seen;
  } ctx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic [9:0] status_code;
    logic [1:0] error_code;
    logic       final_item;
  } res_t;

  localparam ctx_t CTX_RESET = '{
    phase: PH_STATUS, line_pos: '0, status_value: '0, head_error: 1'b0,
    name_match: 2'b11, value_accum: '0, digit_count: '0, val_started: 1'b0,
    val_gap: 1'b0, val_bad: 1'b0, semi_seen: 1'b0
  };

  function automatic logic [7:0] lower(logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") ? 8'(ch + 8'd32) : ch;
  endfunction

  function automatic ctx_t value_clear(ctx_t c_in);
    ctx_t c;
    c = c_in;
    c.value_accum = '0;
    c.digit_count = '0;
    c.val_started = 1'b0;
    c.val_gap     = 1'b0;
    c.val_bad     = 1'b0;
    c.semi_seen   = 1'b0;
    return c;
  endfunction

  function automatic ctx_t token_char(ctx_t c_in, logic [7:0] ch, logic [1:0] tok);
    ctx_t c;
    logic [3:0] d;
    logic hex_ok;
    c = c_in;
    d = '0;
    hex_ok = 1'b1;
    if (ch == CH_SP || ch == CH_TAB) begin
      if (c.val_started) c.val_gap = 1'b1;
    end else begin
      if (c.val_gap) c.val_bad = 1'b1;
      c.val_started = 1'b1;
      if (c.digit_count < 5'd31) c.digit_count = c.digit_count + 5'd1;
      unique case (tok)
        TOK_DEC: begin
          if (ch < "0" || ch > "9") begin
            c.val_bad = 1'b1;
          end else if (c.digit_count <= DEC_DIGITS_MAX) begin
            c.value_accum = (c.value_accum << 3) + (c.value_accum << 1)
                          + 64'(ch - 8'h30);
          end
        end
        TOK_TE: begin
          if (c.digit_count > 5'd7 ||
              lower(ch) != TE_VALUE[3'(4'd8 - {1'b0, c.digit_count[2:0]})])
            c.val_bad = 1'b1;
        end
        TOK_HEX: begin
          if (ch >= "0" && ch <= "9")      d = 4'(ch - 8'h30);
          else if (ch >= "a" && ch <= "f") d = 4'(ch - 8'h57);
          else if (ch >= "A" && ch <= "F") d = 4'(ch - 8'h37);
          else hex_ok = 1'b0;
          if (!hex_ok) c.val_bad = 1'b1;
          else if (c.digit_count <= HEX_DIGITS_MAX)
            c.value_accum = {c.value_accum[59:0], d};
        end
        TOK_OTHER: ;
      endcase
    end
    return c;
  endfunction

  function automatic ctx_t head_content(ctx_t c_in, logic [7:0] ch);
    ctx_t c;
    logic [8:0] p;
    logic [1:0] tok;
    c = c_in;
    p = c.line_pos;
    if (c.line_pos != 9'd511) c.line_pos = c.line_pos + 9'd1;
    if (c.phase == PH_STATUS) begin
      if (p < 9'd7) begin
        if (ch != PROTO_TAG[3'(3'd7 - p[2:0])]) c.head_error = 1'b1;
      end else if (p == 9'd7) begin
        if (ch != "0" && ch != "1") c.head_error = 1'b1;
      end else if (p == 9'd8) begin
        if (ch != CH_SP) c.head_error = 1'b1;
      end else if (p < 9'd12) begin
        if (ch >= "0" && ch <= "9")
          c.status_value = (c.status_value << 3) + (c.status_value << 1)
                         + 10'(ch - 8'h30);
        else
          c.head_error = 1'b1;
      end else if (p == 9'd12) begin
        if (ch != CH_SP) c.head_error = 1'b1;
      end
    end else if (c.phase == PH_HNAME) begin
      if (p == 9'd0 && (ch == CH_SP || ch == CH_TAB)) c.head_error = 1'b1;
      if (ch == CH_COL) begin
        if (p == 9'd0) c.head_error = 1'b1;
        c.name_match = {c.name_match[1] && p == 9'd17, c.name_match[0] && p == 9'd14};
        c = value_clear(c);
        c.phase = PH_HVALUE;
      end else begin
        if (p >= 9'd14 || lower(ch) != CL_NAME[4'(4'd15 - p[3:0])])
          c.name_match[0] = 1'b0;
        if (p >= 9'd17 || lower(ch) != TE_NAME[5'(5'd31 - p[4:0])])
          c.name_match[1] = 1'b0;
      end
    end else begin
      tok = (c.name_match == 2'd1) ? TOK_DEC :
            ((c.name_match == 2'd2) ? TOK_TE : TOK_OTHER);
      c = token_char(c, ch, tok);
    end
    return c;
  endfunction

  function automatic ctx_t line_content(ctx_t c_in, logic [7:0] ch);
    ctx_t c;
    c = c_in;
    if (c.phase <= PH_HVALUE) begin
      c = head_content(c, ch);
    end else if (c.phase == PH_CHLINE && !c.semi_seen) begin
      if (ch == CH_SEMI) c.semi_seen = 1'b1;
      else c = token_char(c, ch, TOK_HEX);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/http_response_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_response_deframer_unit - HTTP/1.x response head parser and body framer
// Checks the status line, picks up the framing headers and forwards body beats.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / fields                            tuser / tlast
//  s_axis    in   [7:0] rx_byte                             tuser[0] link_closed
//  m_axis    out  [7:0] body_byte [17:8] status [19:18] err tuser[1:0] kind, tlast final
//  apb       in   0x0 head_limit, 0x4 body_limit            pready tied high
//
//  One beat per clock unless a result is stalled: each accepted beat is parsed
//  by combinational line/byte logic between the state and result registers.
//  The longest path is one header-value digit step on the 64-bit accumulator
//  into the Content-Length compare, or a hex digit into the chunk-sum add
//  and body-limit compare.
//  Reset (async, active low) puts the parser at the status line, limits at
//  8192 and 1048576. No clearing pass.
//  A stalled result holds s_axis_tready low only while m_axis_tready is low.
//  After the final result of a response all further beats are swallowed.
// ----------------------------------------------------------------------------
module http_response_deframer_unit
  import hrd_pkg::*;
#(
  parameter int CHUNK_LINE_MAX = 256,
  parameter int TRAILER_MAX    = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // receive stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] link_closed
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] body_byte, [17:8] status_code,
                                           // [19:18] error_code, [23:20] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,   // final_item
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LINE_MAX = (CHUNK_LINE_MAX > TRAILER_MAX) ? CHUNK_LINE_MAX : TRAILER_MAX;
  localparam int LCW      = $clog2(LINE_MAX + 2);
  localparam int TTW      = $clog2(2 * TRAILER_MAX + 2);

  // config registers
  logic [19:0] head_limit_q;
  logic [31:0] body_limit_q;

  // parser state
  ctx_t           ctx_q, ctx_d;
  logic [20:0]    head_count_q, head_count_d;
  logic [63:0]    length_value_q, length_value_d;
  logic           length_seen_q, length_seen_d;
  logic           chunked_q, chunked_d;
  logic [31:0]    remaining_q, remaining_d;
  logic [31:0]    body_total_q, body_total_d;
  logic [TTW-1:0] trailer_total_q, trailer_total_d;
  logic [LCW-1:0] line_count_q, line_count_d;
  logic           cr_held_q, cr_held_d;

  // result register
  logic res_valid_q;
  res_t res_q;
  logic res_v;
  res_t res_d;

  logic in_fire;
  logic cfg_wr;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;
  assign s_axis_tready = !res_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.error_code, res_q.status_code, res_q.body_byte};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.final_item;

  assign prdata = (paddr[2] == REG_BODY_LIMIT) ? body_limit_q : {12'd0, head_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_limit_q <= 20'd8192;
      body_limit_q <= 32'd1048576;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HEAD_LIMIT: head_limit_q <= pwdata[19:0];
        REG_BODY_LIMIT: body_limit_q <= pwdata;
      endcase
    end
  end

  // one byte of parsing
  always_comb begin
    ctx_t c;
    logic [7:0] b;
    logic ended;
    logic head_done;
    logic o_v, o_fin;
    logic [1:0] o_kind, o_code;
    logic [7:0] o_byte;
    logic [LCW-1:0] len;
    logic [64:0] chunk_sum;

    c               = ctx_q;
    b               = s_axis_tdata;
    ended           = 1'b0;
    head_done       = 1'b0;
    o_v             = 1'b0;
    o_fin           = 1'b0;
    o_kind          = KIND_BYTE;
    o_code          = ERR_PROTO;
    o_byte          = '0;
    len             = '0;
    chunk_sum       = '0;
    head_count_d    = head_count_q;
    length_value_d  = length_value_q;
    length_seen_d   = length_seen_q;
    chunked_d       = chunked_q;
    remaining_d     = remaining_q;
    body_total_d    = body_total_q;
    trailer_total_d = trailer_total_q;
    line_count_d    = line_count_q;
    cr_held_d       = cr_held_q;

    if (ctx_q.phase == PH_DONE) begin
      // swallow
    end else if (s_axis_tuser[0]) begin
      o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR;
      if (c.phase <= PH_HVALUE || c.phase == PH_LENGTH) o_code = ERR_PROTO;
      else if (c.phase == PH_CLOSE) o_kind = KIND_DONE;
      else o_code = ERR_CLOSED;
    end else begin
      unique case (c.phase)
        PH_CHDATA: begin
          remaining_d = remaining_q - 32'd1;
          if (remaining_d == '0) c.phase = PH_CHCR;
          o_v = 1'b1; o_byte = b;
        end
        PH_CHCR: begin
          if (b != CH_CR) begin
            o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR;
          end else c.phase = PH_CHLF;
        end
        PH_CHLF: begin
          if (b != CH_LF) begin
            o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR;
          end else begin
            c = value_clear(c);
            c.phase = PH_CHLINE;
            line_count_d = '0;
          end
        end
        PH_LENGTH: begin
          remaining_d = remaining_q - 32'd1;
          o_v = 1'b1; o_byte = b; o_fin = (remaining_d == '0);
        end
        PH_CLOSE: begin
          o_v = 1'b1;
          if (body_total_q >= body_limit_q) begin
            o_fin = 1'b1; o_kind = KIND_ERR; o_code = ERR_BIG;
          end else begin
            body_total_d = body_total_q + 32'd1;
            o_byte = b;
          end
        end
        default: begin
          // line phases: head, chunk size line, trailers
          if (cr_held_q) begin
            if (b == CH_LF) begin
              cr_held_d = 1'b0;
              ended = 1'b1;
            end else begin
              c = line_content(c, CH_CR);
              if (b != CH_CR) begin
                cr_held_d = 1'b0;
                c = line_content(c, b);
              end
            end
          end else if (b == CH_CR) begin
            cr_held_d = 1'b1;
          end else begin
            c = line_content(c, b);
          end

          if (c.phase <= PH_HVALUE) begin
            head_count_d = head_count_q + 21'd1;
            if (ended) begin
              if (c.phase == PH_STATUS) begin
                if (c.line_pos < 9'd12) c.head_error = 1'b1;
              end else if (c.phase == PH_HNAME) begin
                if (c.line_pos == 9'd0) head_done = 1'b1;
                else c.head_error = 1'b1;
              end else if (c.name_match == 2'd1) begin
                if (c.val_bad || c.digit_count == '0 || c.digit_count > DEC_DIGITS_MAX)
                  c.head_error = 1'b1;
                else if (length_seen_q && c.value_accum != length_value_q)
                  c.head_error = 1'b1;
                else begin
                  length_value_d = c.value_accum;
                  length_seen_d  = 1'b1;
                end
              end else if (c.name_match == 2'd2) begin
                if (c.val_bad || c.digit_count != 5'd7) c.head_error = 1'b1;
                else chunked_d = 1'b1;
              end
              if (!head_done) begin
                c.phase      = PH_HNAME;
                c.line_pos   = '0;
                c.name_match = 2'b11;
              end
            end
            if (head_done) begin
              // blank line: decide the framing
              if (c.head_error || (chunked_d && length_seen_d) ||
                  c.status_value < 10'd100 || c.status_value > STATUS_TOP) begin
                o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR;
              end else if (c.status_value < 10'd200) begin
                c              = CTX_RESET;
                head_count_d   = '0;
                length_value_d = '0;
                length_seen_d  = 1'b0;
                chunked_d      = 1'b0;
                cr_held_d      = 1'b0;
              end else begin
                line_count_d = '0;
                cr_held_d    = 1'b0;
                c = value_clear(c);
                if (chunked_d) c.phase = PH_CHLINE;
                else if (length_seen_d) begin
                  if (length_value_d > 64'(body_limit_q)) begin
                    o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR; o_code = ERR_BIG;
                  end else if (length_value_d == '0) begin
                    o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_DONE;
                  end else begin
                    remaining_d = length_value_d[31:0];
                    c.phase = PH_LENGTH;
                  end
                end else c.phase = PH_CLOSE;
              end
            end else if (head_count_d > {1'b0, head_limit_q}) begin
              o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR; o_code = ERR_BIG;
            end
          end else begin
            line_count_d = line_count_q + LCW'(1);
            if (c.phase == PH_CHLINE) begin
              if (ended) begin
                line_count_d = '0;
                chunk_sum = 65'(c.value_accum) + 65'(body_total_q);
                if (c.val_bad || c.digit_count == '0 || c.digit_count > HEX_DIGITS_MAX) begin
                  o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR;
                end else if (c.value_accum == '0) begin
                  c = value_clear(c);
                  c.phase = PH_TRAILER;
                end else if (chunk_sum > 65'(body_limit_q)) begin
                  o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR; o_code = ERR_BIG;
                end else begin
                  remaining_d  = c.value_accum[31:0];
                  body_total_d = chunk_sum[31:0];
                  c = value_clear(c);
                  c.phase = PH_CHDATA;
                end
              end else if (line_count_d > LCW'(CHUNK_LINE_MAX)) begin
                o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR;
              end
            end else begin
              if (ended) begin
                len = line_count_d - LCW'(2);
                line_count_d = '0;
                if (len == '0) begin
                  o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_DONE;
                end else begin
                  trailer_total_d = trailer_total_q + TTW'(len);
                  if (trailer_total_d > TTW'(TRAILER_MAX)) begin
                    o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR; o_code = ERR_BIG;
                  end
                end
              end else if (line_count_d > LCW'(TRAILER_MAX)) begin
                o_v = 1'b1; o_fin = 1'b1; o_kind = KIND_ERR; o_code = ERR_BIG;
              end
            end
          end
        end
      endcase
    end

    if (o_v && o_fin) c.phase = PH_DONE;
    ctx_d             = c;
    res_v             = o_v;
    res_d.kind        = o_kind;
    res_d.body_byte   = (o_kind == KIND_BYTE) ? o_byte : 8'd0;
    res_d.status_code = (o_kind == KIND_ERR) ? 10'd0 : c.status_value;
    res_d.error_code  = (o_kind == KIND_ERR) ? o_code : ERR_PROTO;
    res_d.final_item  = o_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q           <= CTX_RESET;
      head_count_q    <= '0;
      length_value_q  <= '0;
      length_seen_q   <= 1'b0;
      chunked_q       <= 1'b0;
      remaining_q     <= '0;
      body_total_q    <= '0;
      trailer_total_q <= '0;
      line_count_q    <= '0;
      cr_held_q       <= 1'b0;
      res_valid_q     <= 1'b0;
    end else if (in_fire) begin
      ctx_q           <= ctx_d;
      head_count_q    <= head_count_d;
      length_value_q  <= length_value_d;
      length_seen_q   <= length_seen_d;
      chunked_q       <= chunked_d;
      remaining_q     <= remaining_d;
      body_total_q    <= body_total_d;
      trailer_total_q <= trailer_total_d;
      line_count_q    <= line_count_d;
      cr_held_q       <= cr_held_d;
      res_valid_q     <= res_v;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_v) res_q <= res_d;
  end

  // a finished response produces nothing more
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ctx_q.phase == PH_DONE |=> !res_valid_q)
    else $error("result after final item");

  // a final result parks the parser
  a_final_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_v && res_d.final_item |=> ctx_q.phase == PH_DONE)
    else $error("final item without done phase");

  // body phases always have bytes left
  a_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.phase == PH_LENGTH || ctx_q.phase == PH_CHDATA) |-> remaining_q != '0)
    else $error("body phase with zero remaining");

  // errors end the response and carry no status
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.kind == KIND_ERR |-> res_q.final_item && res_q.status_code == '0)
    else $error("malformed error item");

endmodule
`default_nettype wire

// File: sim/tb_http_response_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_response_deframer_unit - self-checking bench for the response deframer
// Streams one HTTP/1.x response (1xx heads, a final head, then a chunked, length
// or close framed body) byte by byte, predicts every result beat in-bench and
// compares each output beat field by field. Limits are rewritten between body
// segments while the parser is quiet.
// ----------------------------------------------------------------------------
module tb_http_response_deframer_unit;
  import hrd_pkg::*;

  localparam int LINE_CAP    = 256;   // chunk size line cap of the dut
  localparam int TRAILER_CAP = 1024;  // trailer byte budget of the dut
  localparam int SEG_BEATS   = 480;   // minimum beats per body segment

  typedef struct {
    logic [7:0] data;
    logic       closed;
  } rx_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  http_response_deframer_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  rx_beat_t rx_pending[$];   // bytes still to be sent
  res_t     result_q[$];     // predicted result beats, oldest first
  int       fail_count = 0;
  int       gap_mode = 0;    // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  bit       rx_taken = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor state: a parallel copy of the parser, advanced per accepted beat
  // --------------------------------------------------------------------------
  logic [19:0] hd_limit;
  logic [31:0] bd_limit;
  logic [3:0]  ph;
  int unsigned head_cnt, line_pos, line_cnt, trl_tot, dcnt;
  logic [9:0]  st_val;
  bit          head_err, len_seen, is_chunked, cr_held;
  bit          vstart, vgap, vbad, semi;
  logic [1:0]  nm;           // bit0 content-length alive, bit1 transfer-encoding
  logic [63:0] acc, len_v, remaining, body_tot;

  string PROTO = "HTTP/1.";
  string CLN   = "content-length";
  string TEN   = "transfer-encoding";
  string TEV   = "chunked";

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  task automatic put_result(logic [1:0] k, logic [7:0] b, logic [1:0] code, bit fin);
    res_t r;
    r.kind        = k;
    r.body_byte   = b;
    r.status_code = (k == KIND_ERR) ? 10'd0 : st_val;
    r.error_code  = code;
    r.final_item  = fin;
    result_q.push_back(r);
    if (fin) ph = PH_DONE;
  endtask

  task automatic put_error(logic [1:0] code);
    put_result(KIND_ERR, 8'h00, code, 1'b1);
  endtask

  task automatic token_reset();
    acc = '0; dcnt = 0; vstart = 0; vgap = 0; vbad = 0; semi = 0;
  endtask

  task automatic head_reset();
    ph = PH_STATUS; head_cnt = 0; line_pos = 0; st_val = '0; head_err = 0;
    nm = 2'b11; len_v = '0; len_seen = 0; is_chunked = 0; cr_held = 0;
    token_reset();
  endtask

  task automatic token_char(logic [7:0] c, logic [1:0] tok);
    logic [3:0] d;
    if (c == CH_SP || c == CH_TAB) begin
      if (vstart) vgap = 1;
      return;
    end
    if (vgap) vbad = 1;
    vstart = 1;
    if (dcnt < 31) dcnt++;
    case (tok)
      TOK_DEC: begin
        if (c < "0" || c > "9") vbad = 1;
        else if (dcnt <= 19) acc = acc * 10 + 64'(c - "0");
      end
      TOK_TE: begin
        if (dcnt > 7 || fold_case(c) != TEV[dcnt-1]) vbad = 1;
      end
      TOK_HEX: begin
        if (c >= "0" && c <= "9") d = 4'(c - "0");
        else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
        else begin
          vbad = 1;
          return;
        end
        if (dcnt <= 15) acc = acc * 16 + 64'(d);
      end
      default: ;
    endcase
  endtask

  task automatic head_char(logic [7:0] c);
    int unsigned p;
    p = line_pos;
    if (line_pos < 511) line_pos++;
    if (ph == PH_STATUS) begin
      if (p < 7) begin
        if (c != PROTO[p]) head_err = 1;
      end else if (p == 7) begin
        if (c != "0" && c != "1") head_err = 1;
      end else if (p == 8 || p == 12) begin
        if (c != CH_SP) head_err = 1;
      end else if (p < 12) begin
        if (c >= "0" && c <= "9") st_val = st_val * 10 + 10'(c - "0");
        else head_err = 1;
      end
    end else if (ph == PH_HNAME) begin
      if (p == 0 && (c == CH_SP || c == CH_TAB)) head_err = 1;
      if (c == CH_COL) begin
        if (p == 0) head_err = 1;
        nm = {nm[1] && p == 17, nm[0] && p == 14};
        token_reset();
        ph = PH_HVALUE;
      end else begin
        if (p >= 14 || fold_case(c) != CLN[p]) nm[0] = 0;
        if (p >= 17 || fold_case(c) != TEN[p]) nm[1] = 0;
      end
    end else begin
      token_char(c, (nm == 2'd1) ? TOK_DEC : ((nm == 2'd2) ? TOK_TE : TOK_OTHER));
    end
  endtask

  task automatic line_char(logic [7:0] c);
    if (ph <= PH_HVALUE) head_char(c);
    else if (ph == PH_CHLINE && !semi) begin
      if (c == CH_SEMI) semi = 1;
      else token_char(c, TOK_HEX);
    end
  endtask

  // blank line: pick the framing or drop an informational head
  task automatic head_done();
    if (head_err || (is_chunked && len_seen) || st_val < 100 || st_val > STATUS_TOP) begin
      put_error(ERR_PROTO);
      return;
    end
    if (st_val < 200) begin
      head_reset();
      return;
    end
    line_cnt = 0; cr_held = 0;
    token_reset();
    if (is_chunked) ph = PH_CHLINE;
    else if (len_seen) begin
      if (len_v > 64'(bd_limit)) put_error(ERR_BIG);
      else if (len_v == 0) put_result(KIND_DONE, 8'h00, ERR_PROTO, 1'b1);
      else begin
        remaining = len_v;
        ph = PH_LENGTH;
      end
    end else ph = PH_CLOSE;
  endtask

  task automatic head_eol(output bit over);
    over = 0;
    if (ph == PH_STATUS) begin
      if (line_pos < 12) head_err = 1;
    end else if (ph == PH_HNAME) begin
      if (line_pos == 0) begin
        head_done();
        over = 1;
        return;
      end
      head_err = 1;
    end else if (nm == 2'd1) begin
      if (vbad || dcnt == 0 || dcnt > 19) head_err = 1;
      else if (len_seen && acc != len_v) head_err = 1;
      else begin
        len_v = acc;
        len_seen = 1;
      end
    end else if (nm == 2'd2) begin
      if (vbad || dcnt != 7) head_err = 1;
      else is_chunked = 1;
    end
    ph = PH_HNAME; line_pos = 0; nm = 2'b11;
  endtask

  task automatic chunk_size_eol();
    logic [63:0] size;
    size = acc;
    line_cnt = 0;
    if (vbad || dcnt == 0 || dcnt > 15) begin
      put_error(ERR_PROTO);
      return;
    end
    token_reset();
    if (size == 0) ph = PH_TRAILER;
    else if (body_tot + size > 64'(bd_limit)) put_error(ERR_BIG);
    else begin
      remaining = size;
      body_tot += size;
      ph = PH_CHDATA;
    end
  endtask

  task automatic trailer_eol();
    int unsigned len;
    len = line_cnt - 2;
    line_cnt = 0;
    if (len == 0) put_result(KIND_DONE, 8'h00, ERR_PROTO, 1'b1);
    else begin
      trl_tot += len;
      if (trl_tot > TRAILER_CAP) put_error(ERR_BIG);
    end
  endtask

  task automatic deframe_beat(logic [7:0] b, bit closed);
    bit eol, over;
    eol = 0;
    if (ph == PH_DONE) return;
    if (closed) begin
      if (ph <= PH_HVALUE || ph == PH_LENGTH) put_error(ERR_PROTO);
      else if (ph == PH_CLOSE) put_result(KIND_DONE, 8'h00, ERR_PROTO, 1'b1);
      else put_error(ERR_CLOSED);
      return;
    end
    case (ph)
      PH_CHDATA: begin
        remaining--;
        if (remaining == 0) ph = PH_CHCR;
        put_result(KIND_BYTE, b, ERR_PROTO, 1'b0);
        return;
      end
      PH_CHCR: begin
        if (b != CH_CR) put_error(ERR_PROTO);
        else ph = PH_CHLF;
        return;
      end
      PH_CHLF: begin
        if (b != CH_LF) put_error(ERR_PROTO);
        else begin
          ph = PH_CHLINE;
          line_cnt = 0;
          token_reset();
        end
        return;
      end
      PH_LENGTH: begin
        remaining--;
        put_result(KIND_BYTE, b, ERR_PROTO, remaining == 0);
        return;
      end
      PH_CLOSE: begin
        if (body_tot >= 64'(bd_limit)) put_error(ERR_BIG);
        else begin
          body_tot++;
          put_result(KIND_BYTE, b, ERR_PROTO, 1'b0);
        end
        return;
      end
      default: ;
    endcase
    // line framing: a CR is held until we know whether LF follows
    if (cr_held) begin
      if (b == CH_LF) begin
        cr_held = 0;
        eol = 1;
      end else begin
        line_char(CH_CR);
        if (b != CH_CR) begin
          cr_held = 0;
          line_char(b);
        end
      end
    end else if (b == CH_CR) cr_held = 1;
    else line_char(b);

    if (ph <= PH_HVALUE) begin
      head_cnt++;
      if (eol) begin
        head_eol(over);
        if (over) return;
      end
      if (head_cnt > hd_limit) put_error(ERR_BIG);
      return;
    end
    line_cnt++;
    if (ph == PH_CHLINE) begin
      if (eol) chunk_size_eol();
      else if (line_cnt > LINE_CAP) put_error(ERR_PROTO);
      return;
    end
    if (eol) trailer_eol();
    else if (line_cnt > TRAILER_CAP) put_error(ERR_BIG);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check output beats, then feed accepted input beats to the model
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result beat kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tuser != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[7:0] != want.body_byte) begin
          $error("body_byte: expected %h, got %h", want.body_byte, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[17:8] != want.status_code) begin
          $error("status_code: expected %0d, got %0d", want.status_code,
                 m_axis_tdata[17:8]);
          fail_count++;
        end
        if (m_axis_tdata[19:18] != want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code,
                 m_axis_tdata[19:18]);
          fail_count++;
        end
        if (m_axis_tlast != want.final_item) begin
          $error("final_item: expected %0d, got %0d", want.final_item, m_axis_tlast);
          fail_count++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      deframe_beat(s_axis_tdata, s_axis_tuser[0]);
      rx_taken = 1'b1;
    end
  end

  // Driver: one decision per falling edge, valid held until the beat is taken
  always @(negedge clk_i) begin
    bit hold;
    int idle_pct;
    if (rst_ni) begin
      idle_pct = (gap_mode == 3) ? 33 : 65;
      hold = s_axis_tvalid;
      if (rx_taken) begin
        void'(rx_pending.pop_front());
        rx_taken = 1'b0;
        hold = 1'b0;
      end
      if (!hold) begin
        if (rx_pending.size() > 0 &&
            !((gap_mode == 1 || gap_mode == 3) && $urandom_range(99) < idle_pct)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_pending[0].data;
          s_axis_tuser  <= rx_pending[0].closed;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !((gap_mode >= 2) && $urandom_range(99) < idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    rx_beat_t x;
    x.data = b;
    x.closed = 1'b0;
    rx_pending.push_back(x);
  endtask

  task automatic send_close();
    rx_beat_t x;
    x.data = 8'($urandom);
    x.closed = 1'b1;
    rx_pending.push_back(x);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic string mix_case(string s);
    string t;
    t = s;
    foreach (t[i])
      if ($urandom_range(1)) t[i] = (t[i] >= "a" && t[i] <= "z") ? t[i] - 8'd32 : t[i];
    return t;
  endfunction

  // filler header: x- prefix keeps it clear of the framing names
  task automatic send_filler_header();
    int n;
    logic [7:0] b, prev;
    send_text("X-");
    n = $urandom_range(1, 10);
    repeat (n) send_byte(8'("a" + $urandom_range(25)));
    send_byte(CH_COL);
    n = $urandom_range(0, 16);
    prev = 8'h00;
    repeat (n) begin
      b = 8'($urandom);
      if (prev == CH_CR && b == CH_LF) b = "z";
      send_byte(b);
      prev = b;
    end
    send_text("\r\n");
  endtask

  task automatic send_chunk(int unsigned size);
    string hex;
    int n;
    hex = $sformatf("%0h", size);
    if ($urandom_range(1)) hex = hex.toupper();
    n = $urandom_range(0, 2);
    repeat (n) hex = {"0", hex};
    if ($urandom_range(3) == 0) hex = {" ", hex};
    send_text(hex);
    case ($urandom_range(3))
      0: send_text(";ext=1");
      1: send_text(" ");
      default: ;
    endcase
    send_text("\r\n");
    repeat (size) send_byte(8'($urandom));
    send_text("\r\n");
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (rx_pending.size() != 0 || s_axis_tvalid || result_q.size() != 0);
    repeat (8) @(posedge clk_i);  // result register may still be draining
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_HEAD_LIMIT) hd_limit = v[19:0];
    else bd_limit = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int framing, seg, mark, n, body_len, ending;
    hd_limit = 20'd8192; bd_limit = 32'd1048576;
    head_reset();
    remaining = '0; body_tot = '0; trl_tot = 0; line_cnt = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    reg_write(REG_HEAD_LIMIT, 32'(20'hFFFFF));
    reg_write(REG_BODY_LIMIT, 32'hFFFF_FFFF);

    // informational heads are dropped; lone CRs inside values are content
    send_text("HTTP/1.1 100 Continue\r\n\r\n");
    send_text("HTTP/1.0 103 Early\r\nLink: a\rb\r\r\n\r\n");
    n = $urandom_range(1, 3);
    repeat (n) begin
      send_text($sformatf("HTTP/1.1 1%02d x\r\n", $urandom_range(99)));
      repeat ($urandom_range(0, 3)) send_filler_header();
      send_text("\r\n");
    end

    framing = $urandom_range(3);  // 0,1 chunked, 2 length, 3 close
    body_len = 4 * SEG_BEATS;
    send_text($sformatf("HTTP/1.%0d %0d OK\r\n", $urandom_range(1), $urandom_range(200, 599)));
    send_filler_header();
    if (framing <= 1) begin
      send_text({mix_case("transfer-encoding"), ":  ", mix_case("chunked"), " \t\r\n"});
    end else if (framing == 2) begin
      send_text({mix_case("content-length"), ": 00", $sformatf("%0d", body_len), " \r\n"});
      if ($urandom_range(1))
        send_text({mix_case("content-length"), ":", $sformatf("%0d", body_len), "\r\n"});
    end
    send_filler_header();
    send_text("\r\n");

    for (seg = 0; seg < 4; seg++) begin
      wait_quiet();
      case (seg)
        1: begin
          reg_write(REG_HEAD_LIMIT, 32'd16);
          reg_write(REG_BODY_LIMIT, 32'($urandom_range(32'h0100_0000, 32'hFFFF_FFFE)));
        end
        2: reg_write(REG_HEAD_LIMIT, 32'($urandom_range(16, 20'hFFFFF)));
        3: reg_write(REG_BODY_LIMIT, 32'hFFFF_FFFF);
        default: ;
      endcase
      gap_mode = seg;
      mark = rx_pending.size();
      if (framing <= 1) begin
        while (rx_pending.size() - mark < SEG_BEATS)
          send_chunk(($urandom_range(19) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24));
      end else begin
        repeat (SEG_BEATS) send_byte(8'($urandom));
      end
    end

    // how the response ends
    ending = $urandom_range(3);
    if (framing <= 1) begin
      case (ending)
        0: send_close();                       // closed between chunks
        1: begin                               // limit hit by next chunk size
          wait_quiet();
          reg_write(REG_BODY_LIMIT, 32'd0);
          send_chunk(1);
        end
        2: send_text("3\r\nabcX");             // data not followed by CR LF
        default: begin                         // trailers, then blank line
          send_text("0;last\r\n");
          repeat ($urandom_range(0, 3)) send_filler_header();
          send_text("\r\n");
        end
      endcase
    end else if (framing == 3) begin
      if (ending == 0) begin
        wait_quiet();
        reg_write(REG_BODY_LIMIT, 32'd0);
        send_byte(8'hA5);
      end else begin
        send_close();
      end
    end
    // everything after the final beat is swallowed
    repeat (5) send_byte(8'($urandom));
    send_close();

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
